// ===== rtl/upff_pkg.sv =====
// ----------------------------------------------------------------------------
// UDP port frame filter package
// Shared types, register indexes, status codes and protocol constants.
// ----------------------------------------------------------------------------
package upff_pkg;

	// Default frame capture limit in bytes.
	localparam int MAX_FRAME_DEF = 2048;

	// Depth of the result queue in front of the output channel.
	localparam int RES_DEPTH = 4;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LISTEN_PORT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 1'b1;

	// Register reset values.
	localparam logic [15:0] LISTEN_PORT_RST = 16'd5000;
	localparam logic [11:0] BUFFER_SIZE_RST = 12'd2048;

	// Protocol constants.
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'h11;
	localparam logic [3:0]  IHL_MASK       = 4'hF;
	localparam int          MIN_FRAME_LEN  = 42;
	localparam int          UDP_HDR_LEN    = 8;
	localparam int          ETH_HDR_LEN    = 14;
	localparam int          MAX_PAY_INDEX  = 2046;

	// Frame byte positions of the fixed header fields.
	localparam int POS_ETYPE_HI = 12;
	localparam int POS_ETYPE_LO = 13;
	localparam int POS_IHL      = 14;
	localparam int POS_PROTO    = 23;

	// Offsets inside the UDP header.
	localparam int UDP_DPORT_HI = 2;
	localparam int UDP_DPORT_LO = 3;
	localparam int UDP_LEN_HI   = 4;
	localparam int UDP_LEN_LO   = 5;

	typedef enum logic {
		RK_PAYLOAD = 1'b0,
		RK_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_SHORT     = 3'd1,
		ST_NOT_IPV4  = 3'd2,
		ST_NOT_UDP   = 3'd3,
		ST_HDR_CUT   = 3'd4,
		ST_PORT      = 3'd5,
		ST_LENGTH    = 3'd6,
		ST_TRUNCATED = 3'd7
	} status_t;

	// One result item as held in the output queue.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [10:0] index;
		status_t     status;
		logic [10:0] plen;
	} result_t;

endpackage

// ===== rtl/upff_if.sv =====
// ----------------------------------------------------------------------------
// UDP port frame filter channels
// Valid/ready channels for frame bytes, results and register writes.
// ----------------------------------------------------------------------------

// Frame byte channel.
interface upff_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

// Result channel.
interface upff_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  data_byte;
	logic [10:0] byte_index;
	logic [2:0]  status;
	logic [10:0] payload_length;

	modport source (
		output valid, output result_kind, output data_byte, output byte_index,
		output status, output payload_length, input ready
	);
	modport sink (
		input valid, input result_kind, input data_byte, input byte_index,
		input status, input payload_length, output ready
	);
endinterface

// Register write channel.
interface upff_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [upff_pkg::CFG_IDX_W-1:0]   index;
	logic [upff_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/udp_port_frame_filter.sv =====
// Results of a byte go into the result queue when the byte is accepted.
// One frame byte per cycle is taken while the input is ready; a final byte
// inside the payload window yields two results, drained through a four-entry
// result queue. The byte input is ready while the queue has room for two more
// results. Reset (arst_n low) clears the frame state and the queue and restores
// listen_port to 5000 and buffer_size to 2048.
// ----------------------------------------------------------------------------
// UDP port frame filter
// Tracks Ethernet/IPv4/UDP headers byte by byte, forwards payload bytes with
// their index and gives a verdict at the end of each frame.
// ----------------------------------------------------------------------------
module udp_port_frame_filter #(
	parameter int MAX_FRAME = upff_pkg::MAX_FRAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	upff_rx_if.sink           rx,
	upff_res_if.source        res,
	upff_cfg_if.sink          cfg
);
	import upff_pkg::*;

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int SW = (CW + 1 > 18) ? CW + 1 : 18;
	localparam int PW = $clog2(RES_DEPTH);
	localparam int NW = $clog2(RES_DEPTH + 1);

	// Configuration registers.
	logic [15:0] listen_port_q;
	logic [11:0] buffer_size_q;

	// Per-frame state.
	logic [CW-1:0] byte_count_q;
	logic [15:0]   ether_type_q;
	logic [7:0]    protocol_byte_q;
	logic [5:0]    header_bytes_q;
	logic [15:0]   dest_port_q;
	logic [15:0]   udp_length_q;

	// Next frame state.
	logic [CW-1:0] byte_count_n;
	logic [15:0]   ether_type_n;
	logic [7:0]    protocol_byte_n;
	logic [5:0]    header_bytes_n;
	logic [15:0]   dest_port_n;
	logic [15:0]   udp_length_n;

	// Result queue.
	result_t       fifo_q [RES_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	logic          rx_fire;
	logic          pop;
	logic          active;
	logic [SW-1:0] pos_x;
	logic [SW-1:0] uo_x;
	logic [SW-1:0] po_x;
	logic [SW-1:0] pl_x;
	logic [SW-1:0] idx_x;
	logic [15:0]   pl;
	logic          emit;
	logic [SW-1:0] uo_n_x;
	logic [SW-1:0] len_x;
	logic          len_ok;
	status_t       verdict;
	logic [10:0]   plen;
	result_t       pay_res;
	result_t       ver_res;
	logic [1:0]    push_cnt;

	assign rx_fire   = rx.valid & rx.ready;
	assign pop       = res.valid & res.ready;
	assign cfg.ready = 1'b1;

	// Header offsets of the frame in progress.
	assign active = byte_count_q < CW'(MAX_FRAME);
	assign pos_x  = SW'(byte_count_q);
	assign uo_x   = SW'(ETH_HDR_LEN) + SW'(header_bytes_q);
	assign po_x   = uo_x + SW'(UDP_HDR_LEN);
	assign pl     = (udp_length_q > 16'(UDP_HDR_LEN)) ? udp_length_q - 16'(UDP_HDR_LEN) : '0;
	assign pl_x   = SW'(pl);
	assign idx_x  = pos_x - po_x;

	// Header capture for the current byte.
	always_comb begin
		byte_count_n    = byte_count_q;
		ether_type_n    = ether_type_q;
		protocol_byte_n = protocol_byte_q;
		header_bytes_n  = header_bytes_q;
		dest_port_n     = dest_port_q;
		udp_length_n    = udp_length_q;
		if (active) begin
			byte_count_n = byte_count_q + CW'(1);
			if (pos_x == SW'(POS_ETYPE_HI)) begin
				ether_type_n = {rx.frame_byte, ether_type_q[7:0]};
			end
			if (pos_x == SW'(POS_ETYPE_LO)) begin
				ether_type_n = {ether_type_q[15:8], rx.frame_byte};
			end
			if (pos_x == SW'(POS_IHL)) begin
				header_bytes_n = {rx.frame_byte[3:0] & IHL_MASK, 2'b00};
			end
			if (pos_x == SW'(POS_PROTO)) begin
				protocol_byte_n = rx.frame_byte;
			end
			if (pos_x > SW'(POS_IHL)) begin
				if (pos_x == uo_x + SW'(UDP_DPORT_HI)) begin
					dest_port_n = {rx.frame_byte, dest_port_q[7:0]};
				end
				if (pos_x == uo_x + SW'(UDP_DPORT_LO)) begin
					dest_port_n = {dest_port_q[15:8], rx.frame_byte};
				end
				if (pos_x == uo_x + SW'(UDP_LEN_HI)) begin
					udp_length_n = {rx.frame_byte, udp_length_q[7:0]};
				end
				if (pos_x == uo_x + SW'(UDP_LEN_LO)) begin
					udp_length_n = {udp_length_q[15:8], rx.frame_byte};
				end
			end
		end
	end

	// A byte inside the payload window is forwarded.
	assign emit = active && (pos_x >= po_x) && (idx_x < pl_x) && (idx_x <= SW'(MAX_PAY_INDEX));

	// End-of-frame verdict, judged on the state including this byte.
	assign uo_n_x = SW'(ETH_HDR_LEN) + SW'(header_bytes_n);
	assign len_x  = SW'(byte_count_n);
	assign len_ok = (udp_length_n > 16'(UDP_HDR_LEN)) &&
		(SW'(udp_length_n) < SW'(buffer_size_q) + SW'(UDP_HDR_LEN));
	assign plen   = 11'(udp_length_n - 16'(UDP_HDR_LEN));

	always_comb begin
		if (len_x < SW'(MIN_FRAME_LEN)) begin
			verdict = ST_SHORT;
		end else if (ether_type_n != ETHERTYPE_IPV4) begin
			verdict = ST_NOT_IPV4;
		end else if (protocol_byte_n != PROTO_UDP) begin
			verdict = ST_NOT_UDP;
		end else if (uo_n_x + SW'(UDP_HDR_LEN) > len_x) begin
			verdict = ST_HDR_CUT;
		end else if (dest_port_n != listen_port_q) begin
			verdict = ST_PORT;
		end else if (!len_ok) begin
			verdict = ST_LENGTH;
		end else if (uo_n_x + SW'(udp_length_n) > len_x) begin
			verdict = ST_TRUNCATED;
		end else begin
			verdict = ST_ACCEPTED;
		end
	end

	// Result items for the current byte.
	always_comb begin
		pay_res        = '0;
		pay_res.kind   = RK_PAYLOAD;
		pay_res.data   = rx.frame_byte;
		pay_res.index  = idx_x[10:0];
		pay_res.status = ST_ACCEPTED;
		ver_res        = '0;
		ver_res.kind   = RK_VERDICT;
		ver_res.status = verdict;
		ver_res.plen   = (verdict == ST_ACCEPTED) ? plen : '0;
	end

	assign push_cnt = rx_fire ? (2'(emit) + 2'(rx.frame_last)) : 2'd0;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listen_port_q <= LISTEN_PORT_RST;
			buffer_size_q <= BUFFER_SIZE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LISTEN_PORT: listen_port_q <= cfg.data;
				REG_BUFFER_SIZE: buffer_size_q <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// Frame state; cleared after each verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			ether_type_q    <= '0;
			protocol_byte_q <= '0;
			header_bytes_q  <= '0;
			dest_port_q     <= '0;
			udp_length_q    <= '0;
		end else if (rx_fire) begin
			if (rx.frame_last) begin
				byte_count_q    <= '0;
				ether_type_q    <= '0;
				protocol_byte_q <= '0;
				header_bytes_q  <= '0;
				dest_port_q     <= '0;
				udp_length_q    <= '0;
			end else begin
				byte_count_q    <= byte_count_n;
				ether_type_q    <= ether_type_n;
				protocol_byte_q <= protocol_byte_n;
				header_bytes_q  <= header_bytes_n;
				dest_port_q     <= dest_port_n;
				udp_length_q    <= udp_length_n;
			end
		end
	end

	// Result queue storage; the payload byte goes in ahead of the verdict.
	always_ff @(posedge clk) begin
		if (rx_fire) begin
			if (emit && rx.frame_last) begin
				fifo_q[wr_ptr_q]          <= pay_res;
				fifo_q[wr_ptr_q + PW'(1)] <= ver_res;
			end else if (emit) begin
				fifo_q[wr_ptr_q] <= pay_res;
			end else if (rx.frame_last) begin
				fifo_q[wr_ptr_q] <= ver_res;
			end
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_cnt);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + NW'(push_cnt) - NW'(pop);
		end
	end

	// Channel outputs.
	assign rx.ready           = count_q <= NW'(RES_DEPTH - 2);
	assign res.valid          = count_q != '0;
	assign res.result_kind    = fifo_q[rd_ptr_q].kind;
	assign res.data_byte      = fifo_q[rd_ptr_q].data;
	assign res.byte_index     = fifo_q[rd_ptr_q].index;
	assign res.status         = fifo_q[rd_ptr_q].status;
	assign res.payload_length = fifo_q[rd_ptr_q].plen;

`ifndef SYNTHESIS
	// The queue never holds more results than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(RES_DEPTH))
		else $error("result queue overflow");

	// A byte is only taken while two result slots are free.
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		rx.ready |-> (count_q <= NW'(RES_DEPTH - 2)))
		else $error("byte accepted without queue room");

	// The frame byte count is cleared after a verdict.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_fire && rx.frame_last) |=> (byte_count_q == '0))
		else $error("frame state not cleared after verdict");

	// The counted length saturates at the frame limit.
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CW'(MAX_FRAME))
		else $error("byte count beyond frame limit");

	// A popped item leaves the fill count lower unless new items came in.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !rx_fire) |=> (count_q == $past(count_q) - NW'(1)))
		else $error("queue count did not drop on pop");
`endif

endmodule

// ===== sim/tb_udp_port_frame_filter.sv =====
// ----------------------------------------------------------------------------
// UDP port frame filter testbench
// Sends Ethernet frames byte by byte through the frame channel and checks
// every payload byte and frame verdict against a cycle-free software model
// of the filter. A directed set of frames covers each verdict and the
// overlong frame; random frames follow under several register settings,
// with bursty input, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_udp_port_frame_filter;
	timeunit 1ns;
	timeprecision 1ps;

	import upff_pkg::*;

	localparam int FRAME_LIMIT = MAX_FRAME_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_BYTES = 320;

	// One frame byte as queued for the sender, with an optional fixed verdict.
	typedef struct {
		logic [7:0]  bval;
		bit          last;
		bit          fixed;
		status_t     st;
		logic [10:0] pl;
	} wire_item_t;

	// Header recipe of one frame.
	typedef struct {
		int          len;
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [15:0] dport;
		logic [15:0] ulen;
		bit          fixed;
		status_t     st;
		logic [10:0] pl;
	} frame_row_t;

	logic clk;
	logic arst_n;

	upff_rx_if  rx_ch ();
	upff_res_if res_ch ();
	upff_cfg_if cfg_ch ();

	udp_port_frame_filter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Directed frames; a fixed verdict is given where it is obvious.
	frame_row_t dir_rows [23] = '{
		'{20,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd18,   1'b1, ST_SHORT,     11'd0},
		'{1,    16'h0800, 4'd5,  8'h11, 16'd5000, 16'd18,   1'b1, ST_SHORT,     11'd0},
		'{41,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd18,   1'b1, ST_SHORT,     11'd0},
		'{60,   16'h86DD, 4'd5,  8'h11, 16'd5000, 16'd18,   1'b1, ST_NOT_IPV4,  11'd0},
		'{60,   16'h0801, 4'd5,  8'h11, 16'd5000, 16'd18,   1'b1, ST_NOT_IPV4,  11'd0},
		'{60,   16'h0000, 4'd5,  8'h11, 16'd5000, 16'd18,   1'b1, ST_NOT_IPV4,  11'd0},
		'{60,   16'h0800, 4'd5,  8'h06, 16'd5000, 16'd18,   1'b1, ST_NOT_UDP,   11'd0},
		'{60,   16'h0800, 4'd15, 8'h11, 16'd5000, 16'd18,   1'b1, ST_HDR_CUT,   11'd0},
		'{60,   16'h0800, 4'd5,  8'h11, 16'd5001, 16'd18,   1'b1, ST_PORT,      11'd0},
		'{60,   16'h0800, 4'd5,  8'h11, 16'hFFFF, 16'd18,   1'b1, ST_PORT,      11'd0},
		'{60,   16'h0800, 4'd5,  8'h11, 16'd0,    16'd18,   1'b1, ST_PORT,      11'd0},
		'{60,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd8,    1'b1, ST_LENGTH,    11'd0},
		'{60,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd0,    1'b1, ST_LENGTH,    11'd0},
		'{80,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'hFFFF, 1'b0, ST_ACCEPTED,  11'd0},
		'{52,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd18,   1'b1, ST_ACCEPTED,  11'd10},
		'{52,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd28,   1'b1, ST_TRUNCATED, 11'd0},
		'{42,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd9,    1'b1, ST_TRUNCATED, 11'd0},
		'{43,   16'h0800, 4'd5,  8'h11, 16'd5000, 16'd9,    1'b1, ST_ACCEPTED,  11'd1},
		'{100,  16'h0800, 4'd5,  8'h11, 16'd5000, 16'd30,   1'b1, ST_ACCEPTED,  11'd22},
		'{60,   16'h0800, 4'd0,  8'h11, 16'd5000, 16'd18,   1'b0, ST_ACCEPTED,  11'd0},
		'{70,   16'h0800, 4'd6,  8'h11, 16'd5000, 16'd20,   1'b0, ST_ACCEPTED,  11'd0},
		'{2100, 16'h0800, 4'd5,  8'h11, 16'd5000, 16'd2014, 1'b0, ST_ACCEPTED,  11'd0},
		'{2049, 16'h0800, 4'd5,  8'h11, 16'd5000, 16'd2015, 1'b0, ST_ACCEPTED,  11'd0}
	};

	// Model state of the filter and its registers.
	logic [15:0] cfg_port;
	logic [11:0] cfg_bufsz;
	logic [11:0] fr_count;
	logic [15:0] etype;
	logic [7:0]  proto;
	logic [5:0]  hdr_bytes;
	logic [15:0] dport;
	logic [15:0] ulen;

	wire_item_t wire_bytes_q [$];
	result_t    frame_results_q [$];

	int bytes_queued;
	int bytes_taken;
	int err_count;
	int cycle_count;

	// Sender and receiver pacing.
	wire_item_t cur_item;
	int         burst_left;
	int         gap_left;
	int         rcv_mode;
	int         rcv_cycle;
	int         hold_left;
	bit         hold_done;

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Verdict of the frame counted so far; plen is the accepted payload length.
	function automatic status_t frame_verdict(output logic [10:0] plen);
		int len;
		int uo;
		int pl;
		len = int'(fr_count);
		uo = ETH_HDR_LEN + hdr_bytes;
		pl = int'(ulen) - UDP_HDR_LEN;
		plen = '0;
		if (len < MIN_FRAME_LEN) return ST_SHORT;
		if (etype != ETHERTYPE_IPV4) return ST_NOT_IPV4;
		if (proto != PROTO_UDP) return ST_NOT_UDP;
		if (uo + UDP_HDR_LEN > len) return ST_HDR_CUT;
		if (dport != cfg_port) return ST_PORT;
		if (pl <= 0 || pl > int'(cfg_bufsz) - 1) return ST_LENGTH;
		if (uo + UDP_HDR_LEN + pl > len) return ST_TRUNCATED;
		plen = pl[10:0];
		return ST_ACCEPTED;
	endfunction

	// Advances the model by one frame byte and queues the results it causes.
	task automatic filter_byte(input wire_item_t it);
		int          pos;
		int          uo;
		int          po;
		int          pl;
		int          idx;
		result_t     r;
		status_t     st;
		logic [10:0] plen;
		if (fr_count < FRAME_LIMIT) begin
			pos = int'(fr_count);
			uo = ETH_HDR_LEN + hdr_bytes;
			po = uo + UDP_HDR_LEN;
			pl = (ulen > UDP_HDR_LEN) ? int'(ulen) - UDP_HDR_LEN : 0;
			if (pos == POS_ETYPE_HI) etype[15:8] = it.bval;
			if (pos == POS_ETYPE_LO) etype[7:0] = it.bval;
			if (pos == POS_IHL) hdr_bytes = {it.bval[3:0] & IHL_MASK, 2'b00};
			if (pos == POS_PROTO) proto = it.bval;
			if (pos > POS_IHL) begin
				if (pos == uo + UDP_DPORT_HI) dport[15:8] = it.bval;
				if (pos == uo + UDP_DPORT_LO) dport[7:0] = it.bval;
				if (pos == uo + UDP_LEN_HI) ulen[15:8] = it.bval;
				if (pos == uo + UDP_LEN_LO) ulen[7:0] = it.bval;
			end
			// Tentative payload byte inside the payload window.
			if (pos > POS_IHL && pos >= po) begin
				idx = pos - po;
				if (idx < pl && idx <= MAX_PAY_INDEX) begin
					r.kind = RK_PAYLOAD;
					r.data = it.bval;
					r.index = idx[10:0];
					r.status = ST_ACCEPTED;
					r.plen = '0;
					frame_results_q.push_back(r);
				end
			end
			fr_count = 12'(pos + 1);
		end
		// Verdict on the final byte, then the frame state starts over.
		if (it.last) begin
			st = frame_verdict(plen);
			if (it.fixed) begin
				st = it.st;
				plen = it.pl;
			end
			r.kind = RK_VERDICT;
			r.data = '0;
			r.index = '0;
			r.status = st;
			r.plen = plen;
			frame_results_q.push_back(r);
			fr_count = '0;
			etype = '0;
			proto = '0;
			hdr_bytes = '0;
			dport = '0;
			ulen = '0;
		end
	endtask

	// Builds the bytes of one frame from its recipe and queues them.
	task automatic push_frame(input frame_row_t row);
		logic [7:0] fb [2200];
		logic [7:0] ver;
		int         uo;
		wire_item_t it;
		for (int i = 0; i < row.len; i++) fb[i] = 8'($urandom);
		ver = 8'($urandom);
		fb[POS_ETYPE_HI] = row.etype[15:8];
		fb[POS_ETYPE_LO] = row.etype[7:0];
		fb[POS_IHL] = {ver[7:4], row.ihl};
		fb[POS_PROTO] = row.proto;
		uo = ETH_HDR_LEN + 4 * row.ihl;
		fb[uo + UDP_DPORT_HI] = row.dport[15:8];
		fb[uo + UDP_DPORT_LO] = row.dport[7:0];
		fb[uo + UDP_LEN_HI] = row.ulen[15:8];
		fb[uo + UDP_LEN_LO] = row.ulen[7:0];
		for (int i = 0; i < row.len; i++) begin
			it.bval = fb[i];
			it.last = (i == row.len - 1);
			it.fixed = row.fixed;
			it.st = row.st;
			it.pl = row.pl;
			wire_bytes_q.push_back(it);
			bytes_queued++;
		end
	endtask

	// Mostly well-formed frames for the current port, the rest broken on purpose.
	function automatic frame_row_t random_frame();
		frame_row_t row;
		int         paylen;
		row.fixed = 1'b0;
		row.st = ST_ACCEPTED;
		row.pl = '0;
		row.etype = ETHERTYPE_IPV4;
		row.proto = PROTO_UDP;
		row.dport = cfg_port;
		row.ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
		paylen = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 48);
		row.ulen = 16'(paylen + UDP_HDR_LEN);
		row.len = ETH_HDR_LEN + 4 * row.ihl + UDP_HDR_LEN + paylen;
		if ($urandom_range(0, 3) == 0) row.len += $urandom_range(0, 20);
		if ($urandom_range(0, 99) >= 65) begin
			case ($urandom_range(0, 7))
				0: row.etype = 16'($urandom);
				1: row.proto = 8'($urandom);
				2: row.dport = 16'($urandom);
				3: row.ulen = 16'($urandom);
				4: row.len = $urandom_range(1, row.len);
				5: row.ihl = 4'($urandom);
				6: row.len = $urandom_range(1, MIN_FRAME_LEN - 1);
				default: row.ulen = row.ulen + 16'($urandom_range(1, 8));
			endcase
		end
		return row;
	endfunction

	// Writes one register through the configuration channel.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_LISTEN_PORT) cfg_port = value;
		else cfg_bufsz = value[11:0];
	endtask

	// Waits until every queued byte is taken and every result has come back.
	task automatic settle();
		while (bytes_taken != bytes_queued || frame_results_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Frame byte sender: bursts of random length with random gaps.
	always @(posedge clk) begin
		if (rx_ch.valid && rx_ch.ready) begin
			filter_byte(cur_item);
			bytes_taken++;
		end
		if (!rx_ch.valid || rx_ch.ready) begin
			if (burst_left > 0 && wire_bytes_q.size() > 0) begin
				cur_item = wire_bytes_q.pop_front();
				rx_ch.valid <= 1'b1;
				rx_ch.frame_byte <= cur_item.bval;
				rx_ch.frame_last <= cur_item.last;
				burst_left--;
			end else begin
				rx_ch.valid <= 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Result receiver: a stall pattern that changes mode, plus one long hold-off.
	always @(posedge clk) begin
		rcv_cycle++;
		if (rcv_cycle % 97 == 0) rcv_mode = $urandom_range(0, 3);
		if (!hold_done && bytes_taken >= 1200) begin
			hold_left = 300;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			case (rcv_mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				2: res_ch.ready <= ($urandom_range(0, 9) != 0);
				default: res_ch.ready <= (rcv_cycle % 8 >= 3);
			endcase
		end
	end

	// Result checker: each transaction against the oldest expected result.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (res_ch.valid && res_ch.ready) begin
			got.kind = kind_t'(res_ch.result_kind);
			got.data = res_ch.data_byte;
			got.index = res_ch.byte_index;
			got.status = status_t'(res_ch.status);
			got.plen = res_ch.payload_length;
			if (frame_results_q.size() == 0) begin
				if (err_count < 10)
					$display("unexpected result: kind=%0d data=%02h idx=%0d st=%0d len=%0d",
						got.kind, got.data, got.index, got.status, got.plen);
				err_count++;
			end else begin
				want = frame_results_q.pop_front();
				if (got !== want) begin
					if (err_count < 10)
						$display("mismatch: want kind=%0d data=%02h idx=%0d st=%0d len=%0d, %s",
							want.kind, want.data, want.index, want.status, want.plen,
							$sformatf("got kind=%0d data=%02h idx=%0d st=%0d len=%0d",
								got.kind, got.data, got.index, got.status, got.plen));
					err_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_udp_port_frame_filter: errors");
			$finish;
		end
	end

	// Reset, directed frames, then random phases under changing registers.
	initial begin
		logic [15:0] port_val;
		logic [11:0] buf_val;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.frame_byte = '0;
		rx_ch.frame_last = 1'b0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LISTEN_PORT;
		cfg_ch.data = '0;
		cfg_port = LISTEN_PORT_RST;
		cfg_bufsz = BUFFER_SIZE_RST;
		fr_count = '0;
		etype = '0;
		proto = '0;
		hdr_bytes = '0;
		dport = '0;
		ulen = '0;
		bytes_queued = 0;
		bytes_taken = 0;
		err_count = 0;
		cycle_count = 0;
		burst_left = 0;
		gap_left = 0;
		rcv_mode = 0;
		rcv_cycle = 0;
		hold_left = 0;
		hold_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) push_frame(dir_rows[i]);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin port_val = 16'd0;      buf_val = 12'd0;    end
				1: begin port_val = 16'hFFFF;   buf_val = 12'd1;    end
				2: begin port_val = 16'($urandom); buf_val = 12'd2048; end
				3: begin port_val = LISTEN_PORT_RST; buf_val = 12'($urandom_range(2, 200)); end
				4: begin port_val = 16'($urandom); buf_val = 12'($urandom_range(1, 2048)); end
				default: begin port_val = 16'($urandom); buf_val = 12'd2047; end
			endcase
			cfg_write(REG_LISTEN_PORT, port_val);
			cfg_write(REG_BUFFER_SIZE, {4'h0, buf_val});
			begin
				int start;
				start = bytes_queued;
				while (bytes_queued - start < PHASE_BYTES) push_frame(random_frame());
			end
			settle();
		end

		if (err_count == 0) begin
			$display("tb_udp_port_frame_filter: clean");
		end else begin
			$display("tb_udp_port_frame_filter: errors");
		end
		$finish;
	end

endmodule

// ===== udp_port_frame_filter.f =====
rtl/upff_pkg.sv
rtl/upff_if.sv
rtl/udp_port_frame_filter.sv
sim/tb_udp_port_frame_filter.sv
